[rtl/tsp_pkg.sv]
package tsp_pkg;

   // Default widths
   localparam int PHASE_BITS_DEF = 16;
   localparam int POS_BITS_DEF   = 24;

   // Symbol codes
   localparam logic [7:0] SYM_STEP  = 8'h46;  // 'F'
   localparam logic [7:0] SYM_LEFT  = 8'h2B;  // '+'
   localparam logic [7:0] SYM_RIGHT = 8'h2D;  // '-'

   // Register indexes on the csr port
   localparam int CSR_ADDR_W = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_STEP_LENGTH = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TURN_PHASE  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_WIDTH  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HALF_HEIGHT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_X     = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_START_Y     = 3'd5;

   // Register reset values
   localparam logic [15:0] STEP_LENGTH_RST = 16'd1280;
   localparam logic [23:0] TURN_PHASE_RST  = 24'd21845;
   localparam logic [14:0] HALF_WIDTH_RST  = 15'd512;
   localparam logic [14:0] HALF_HEIGHT_RST = 15'd384;

   // CORDIC constants
   localparam int ITER_W = 4;
   localparam logic [ITER_W-1:0] LAST_ITER = 4'd15;
   localparam logic signed [17:0] CORDIC_GAIN_INV = 18'sd19898;
   localparam logic signed [17:0] Q15_MAX = 18'sd32767;

   // Arctangent per iteration in 2^-32 turn units
   localparam logic [31:0] ATAN_TURNS [16] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861
   };

   // Controller to datapath commands
   typedef struct packed {
      logic              load;    // input transaction accepted
      logic              rot_en;  // one CORDIC iteration
      logic [ITER_W-1:0] iter;
      logic              mul_s;   // product of sine and step
      logic              mul_c;   // x update, product of cosine and step
      logic              fin;     // y update, load result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_step;
   } status_type;

endpackage

[rtl/tsp_ctrl.sv]
module tsp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  tsp_pkg::status_type status,
   output tsp_pkg::cmd_type    cmd
);
   import tsp_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROT   = 3'd1;
   localparam logic [2:0] ST_MUL_S = 3'd2;
   localparam logic [2:0] ST_MUL_C = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;
   logic              out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      iter_in    = iter_ff;
      cmd        = '0;
      cmd.iter   = iter_ff;
      cmd.load   = accept;
      unique case (state_ff)
         ST_IDLE: begin
            iter_in = '0;
            if (accept && status.is_step) begin
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            cmd.rot_en = 1'b1;
            iter_in    = iter_ff + 1'b1;
            if (iter_ff == LAST_ITER) begin
               state_in = ST_MUL_S;
            end
         end
         ST_MUL_S: begin
            cmd.mul_s = 1'b1;
            state_in  = ST_MUL_C;
         end
         ST_MUL_C: begin
            cmd.mul_c = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            // hold until the result register can take the point
            if (out_free) begin
               cmd.fin  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set on finish, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.fin) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/tsp_datapath.sv]
module tsp_datapath #(
   parameter int PHASE_BITS = tsp_pkg::PHASE_BITS_DEF,
   parameter int POS_BITS   = tsp_pkg::POS_BITS_DEF,
   localparam int CSR_W     = (POS_BITS > PHASE_BITS) ? POS_BITS : PHASE_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [tsp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]            csr_wdata,
   input  logic [7:0]                  req_symbol,
   input  logic                        req_restart,
   output logic signed [POS_BITS-1:0]  rsp_point_x,
   output logic signed [POS_BITS-1:0]  rsp_point_y,
   input  tsp_pkg::cmd_type            cmd,
   output tsp_pkg::status_type         status
);
   import tsp_pkg::*;

   localparam int SUM_W = POS_BITS + 10;

   // Configuration registers
   logic [15:0]           step_length_ff;
   logic [PHASE_BITS-1:0] turn_phase_ff;
   logic [14:0]           half_width_ff;
   logic [14:0]           half_height_ff;
   logic [POS_BITS-1:0]   start_x_ff;
   logic [POS_BITS-1:0]   start_y_ff;

   // Turtle state
   logic [PHASE_BITS-1:0] heading_ff, heading_in;
   logic [POS_BITS-1:0]   pos_x_ff, pos_x_in;
   logic [POS_BITS-1:0]   pos_y_ff, pos_y_in;

   // CORDIC and multiplier
   logic signed [17:0] x_ff, x_in;
   logic signed [17:0] y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic               flip_ff, flip_in;
   logic signed [17:0] xs, ys;
   logic signed [32:0] atan_ext;
   logic signed [17:0] trig_raw, trig_neg, trig_clamp;
   logic signed [33:0] prod, prod_ff;

   // Result register
   logic [POS_BITS-1:0] rsp_x_ff, rsp_y_ff;

   assign status.is_step = (req_symbol == SYM_STEP);
   assign rsp_point_x    = rsp_x_ff;
   assign rsp_point_y    = rsp_y_ff;

   // Round the Q.23 product to Q.8, add, and apply the window limit
   function automatic logic [POS_BITS-1:0] move_coord(
      input logic [POS_BITS-1:0] pos,
      input logic signed [33:0]  p,
      input logic [14:0]         limit
   );
      logic signed [33:0]      rnd;
      logic signed [SUM_W-1:0] delta, sum, lim;
      rnd   = (p + 34'sd16384) >>> 15;
      delta = SUM_W'(rnd);
      sum   = SUM_W'($signed(pos)) + delta;
      lim   = SUM_W'($signed({1'b0, limit, 8'b0}));
      if (sum > lim || sum < -lim) begin
         sum = '0;
      end
      return sum[POS_BITS-1:0];
   endfunction

   // Config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         step_length_ff <= STEP_LENGTH_RST;
         turn_phase_ff  <= TURN_PHASE_RST[PHASE_BITS-1:0];
         half_width_ff  <= HALF_WIDTH_RST;
         half_height_ff <= HALF_HEIGHT_RST;
         start_x_ff     <= '0;
         start_y_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_STEP_LENGTH: step_length_ff <= csr_wdata[15:0];
            CSR_TURN_PHASE:  turn_phase_ff  <= csr_wdata[PHASE_BITS-1:0];
            CSR_HALF_WIDTH:  half_width_ff  <= csr_wdata[14:0];
            CSR_HALF_HEIGHT: half_height_ff <= csr_wdata[14:0];
            CSR_START_X:     start_x_ff     <= csr_wdata[POS_BITS-1:0];
            CSR_START_Y:     start_y_ff     <= csr_wdata[POS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Shared multiplier: sine first, then cosine, sign folded and clamped
   always_comb begin
      trig_raw = cmd.mul_s ? y_ff : x_ff;
      trig_neg = flip_ff ? -trig_raw : trig_raw;
      if (trig_neg > Q15_MAX) begin
         trig_clamp = Q15_MAX;
      end else if (trig_neg < -Q15_MAX) begin
         trig_clamp = -Q15_MAX;
      end else begin
         trig_clamp = trig_neg;
      end
      prod = 34'(trig_clamp) * 34'($signed({1'b0, step_length_ff}));
   end

   // One CORDIC rotation per cycle
   always_comb begin
      xs       = x_ff >>> cmd.iter;
      ys       = y_ff >>> cmd.iter;
      atan_ext = $signed({1'b0, ATAN_TURNS[cmd.iter]});
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      flip_in  = flip_ff;
      if (cmd.load) begin
         // fold quadrants 1 and 2 by a half turn
         flip_in = heading_ff[PHASE_BITS-1] ^ heading_ff[PHASE_BITS-2];
         x_in    = CORDIC_GAIN_INV;
         y_in    = '0;
         z_in    = {heading_ff[PHASE_BITS-2], heading_ff[PHASE_BITS-2],
                    heading_ff[PHASE_BITS-2:0], {(32 - PHASE_BITS){1'b0}}};
      end else if (cmd.rot_en) begin
         if (z_ff[32]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + atan_ext;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - atan_ext;
         end
      end
   end

   // Heading and position
   always_comb begin
      heading_in = heading_ff;
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      if (cmd.load) begin
         if (req_restart) begin
            pos_x_in = start_x_ff;
            pos_y_in = start_y_ff;
         end
         if (req_symbol == SYM_LEFT) begin
            heading_in = heading_ff + turn_phase_ff;
         end else if (req_symbol == SYM_RIGHT) begin
            heading_in = heading_ff - turn_phase_ff;
         end
      end
      if (cmd.mul_c) begin
         pos_x_in = move_coord(pos_x_ff, prod_ff, half_width_ff);
      end
      if (cmd.fin) begin
         pos_y_in = move_coord(pos_y_ff, prod_ff, half_height_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heading_ff <= '0;
         pos_x_ff   <= '0;
         pos_y_ff   <= '0;
      end else begin
         heading_ff <= heading_in;
         pos_x_ff   <= pos_x_in;
         pos_y_ff   <= pos_y_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      if (cmd.mul_s || cmd.mul_c) begin
         prod_ff <= prod;
      end
      if (cmd.fin) begin
         rsp_x_ff <= pos_x_ff;
         rsp_y_ff <= pos_y_in;
      end
   end

endmodule

[rtl/turtle_step_plotter_core.sv]
// After acceptance an 'F' transaction runs 16 CORDIC iterations, a sine
// and then a cosine product on the shared multiplier, and a final update.
// No new request is taken until the 'F' is done (req_stall stays high);
// turns and other symbols are taken one per cycle while no 'F' is busy.
// Reset (synchronous, active high) zeroes heading and position and loads
// register defaults; the result register keeps one point while stalled.
module turtle_step_plotter_core #(
   parameter int PHASE_BITS = tsp_pkg::PHASE_BITS_DEF,
   parameter int POS_BITS   = tsp_pkg::POS_BITS_DEF,
   localparam int CSR_W     = (POS_BITS > PHASE_BITS) ? POS_BITS : PHASE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [tsp_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_W-1:0]               csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_symbol,
   input  logic                           req_restart,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [POS_BITS-1:0]     rsp_point_x,
   output logic signed [POS_BITS-1:0]     rsp_point_y
);
   import tsp_pkg::*;

   cmd_type    cmd;
   status_type status;

   tsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tsp_datapath #(
      .PHASE_BITS (PHASE_BITS),
      .POS_BITS   (POS_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_symbol  (req_symbol),
      .req_restart (req_restart),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y),
      .cmd         (cmd),
      .status      (status)
   );

   // Only one datapath operation per cycle
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.rot_en, cmd.mul_s, cmd.mul_c, cmd.fin}))
      else $error("datapath commands overlap");

   // No new transaction is taken while the rotator runs
   a_rot_stalls: assert property (@(posedge clock) disable iff (reset)
      cmd.rot_en |-> req_stall)
      else $error("input accepted during rotation");

   // Multiply starts only right after the final rotation
   a_mul_after_rot: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_s |-> ($past(cmd.rot_en) && $past(cmd.iter) == LAST_ITER))
      else $error("multiply without full rotation");

   // A pending point is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |-> (!rsp_valid || !rsp_stall))
      else $error("result register overwritten while stalled");

endmodule
